// ===== design/mdio_controller_with_phy_regs_core_defines.svh =====
// Assertion macros shared by the checker files of the MDIO controller.
`ifndef MDIO_CONTROLLER_WITH_PHY_REGS_CORE_DEFINES_SVH
`define MDIO_CONTROLLER_WITH_PHY_REGS_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MDIOC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mdioc assertion failed");

// Next-cycle implication, disabled during reset.
`define MDIOC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mdioc assertion failed");

`endif

// ===== design/mdioc_pkg.sv =====
`default_nettype none

package mdioc_pkg;

  // Address of the single attached PHY (sets the presence bits).
  localparam int unsigned PHY_ADDRESS = 7;

  // Bus access and its result
  typedef struct packed {
    logic        op;
    logic [7:0]  offset;
    logic [31:0] wdata;
  } req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        bad_offset;
  } rsp_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Controller register slots
  typedef enum logic [3:0] {
    CTRL_REVISION,
    CTRL_CONTROL,
    CTRL_ALIVE,
    CTRL_LINK,
    CTRL_LINK_INT_RAW,
    CTRL_LINK_INT_MASKED,
    CTRL_USER_INT_RAW,
    CTRL_USER_INT_MASKED,
    CTRL_USER_INT_MASK_SET,
    CTRL_USER_INT_MASK_CLEAR,
    CTRL_USER_ACCESS0,
    CTRL_USER_PHYSEL0,
    CTRL_USER_ACCESS1,
    CTRL_USER_PHYSEL1
  } ctrl_idx_t;

  localparam int CTRL_COUNT = 14;

  // Byte offsets
  localparam logic [7:0] OFS_REVISION        = 8'h00;
  localparam logic [7:0] OFS_CONTROL         = 8'h04;
  localparam logic [7:0] OFS_ALIVE           = 8'h08;
  localparam logic [7:0] OFS_LINK            = 8'h0C;
  localparam logic [7:0] OFS_LINK_INT_RAW    = 8'h10;
  localparam logic [7:0] OFS_LINK_INT_MASKED = 8'h14;
  localparam logic [7:0] OFS_USER_INT_RAW    = 8'h20;
  localparam logic [7:0] OFS_USER_INT_MASKED = 8'h24;
  localparam logic [7:0] OFS_USER_INT_SET    = 8'h28;
  localparam logic [7:0] OFS_USER_INT_CLEAR  = 8'h2C;
  localparam logic [7:0] OFS_USER_ACCESS0    = 8'h80;
  localparam logic [7:0] OFS_USER_PHYSEL0    = 8'h84;
  localparam logic [7:0] OFS_USER_ACCESS1    = 8'h88;
  localparam logic [7:0] OFS_USER_PHYSEL1    = 8'h8C;

  // Reset values
  localparam logic [31:0] REVISION_RESET = 32'h0007_0104;
  localparam logic [31:0] CONTROL_RESET  = 32'h8100_00FF;
  localparam logic [31:0] PRESENCE_RESET = 32'h1 | (32'h1 << PHY_ADDRESS);

  // Control register bits
  localparam int CTRL_ENABLE_BIT  = 30;
  localparam int CTRL_IDLE_BIT    = 31;
  localparam int CTRL_SELFCLR_BIT = 19;

  // User access register bits
  localparam int ACC_GO_BIT    = 31;
  localparam int ACC_WRITE_BIT = 30;
  localparam int ACC_ACK_BIT   = 29;
  localparam int ACC_REG_LSB   = 21;

  // PHY control register bits
  localparam int PHY_SOFT_RESET_BIT = 15;
  localparam int PHY_SELFCLR_BIT    = 9;

  // PHY register numbers beyond the standard block 0..6
  localparam logic [4:0] PHY_REG_LAST_STD = 5'd6;
  localparam logic [4:0] PHY_REG_17       = 5'd17;
  localparam logic [4:0] PHY_REG_18       = 5'd18;
  localparam logic [4:0] PHY_REG_26       = 5'd26;
  localparam logic [4:0] PHY_REG_27       = 5'd27;
  localparam logic [4:0] PHY_REG_29       = 5'd29;
  localparam logic [4:0] PHY_REG_30       = 5'd30;
  localparam logic [4:0] PHY_REG_31       = 5'd31;

  localparam int PHY_COUNT = 14;

  localparam logic [15:0] PHY_RESET [PHY_COUNT] = '{
    16'h3100, 16'h782D, 16'h0007, 16'hC0F0, 16'h0081, 16'h0001, 16'h0000,
    16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0040
  };

  // Controller to PHY register file
  typedef struct packed {
    logic        wr;
    logic [4:0]  regnum;
    logic [15:0] data;
  } phy_req_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] rdata;
  } phy_rsp_t;

endpackage

`default_nettype wire

// ===== design/mdioc_phy_regs.sv =====
`default_nettype none

// Register file of the attached PHY: combinational read, one write per cycle.
module mdioc_phy_regs (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mdioc_pkg::phy_req_t req,
  output mdioc_pkg::phy_rsp_t      rsp
);

  logic [15:0] regs [mdioc_pkg::PHY_COUNT];
  logic        hit;
  logic [3:0]  idx;

  // PHY register number to storage slot
  always_comb begin
    hit = 1'b1;
    idx = 4'd0;
    if (req.regnum <= mdioc_pkg::PHY_REG_LAST_STD) begin
      idx = req.regnum[3:0];
    end else begin
      case (req.regnum)
        mdioc_pkg::PHY_REG_17: idx = 4'd7;
        mdioc_pkg::PHY_REG_18: idx = 4'd8;
        mdioc_pkg::PHY_REG_26: idx = 4'd9;
        mdioc_pkg::PHY_REG_27: idx = 4'd10;
        mdioc_pkg::PHY_REG_29: idx = 4'd11;
        mdioc_pkg::PHY_REG_30: idx = 4'd12;
        mdioc_pkg::PHY_REG_31: idx = 4'd13;
        default:               hit = 1'b0;
      endcase
    end
  end

  assign rsp.hit   = hit;
  assign rsp.rdata = regs[idx];

  // Writes; soft reset bit in the control register reloads all defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mdioc_pkg::PHY_COUNT; i++) begin
        regs[i] <= mdioc_pkg::PHY_RESET[i];
      end
    end else if (req.wr && hit) begin
      if (idx == 4'd0) begin
        if (req.data[mdioc_pkg::PHY_SOFT_RESET_BIT]) begin
          for (int i = 0; i < mdioc_pkg::PHY_COUNT; i++) begin
            regs[i] <= mdioc_pkg::PHY_RESET[i];
          end
        end else begin
          regs[0] <= req.data & ~(16'h1 << mdioc_pkg::PHY_SELFCLR_BIT);
        end
      end else begin
        regs[idx] <= req.data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/mdio_controller_with_phy_regs_core.sv =====
`default_nettype none

// MDIO controller register block with one attached PHY register file. Each
// bus access (op, byte offset, write data) produces exactly one response
// (read data, bad-offset flag). Throughput is one access per cycle while
// responses are taken. The access is captured in an input register at its
// transfer edge, then decoded and applied to the register state in a single
// pass that loads the response register. Register state and PHY registers
// change at the edge where the access moves to the response register, so
// each access sees all earlier ones. Request ready drops only during reset
// or while both the input register and the response register are full and
// the response is not taken.
module mdio_controller_with_phy_regs_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire mdioc_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output mdioc_pkg::rsp_t      rsp
);

  logic                 s1_valid;
  mdioc_pkg::req_t      s1;
  logic                 advance;
  logic                 req_xfer;

  logic                 hit;
  mdioc_pkg::ctrl_idx_t idx;
  logic                 do_write;
  logic                 is_access;

  logic [31:0]          ctrl_regs [mdioc_pkg::CTRL_COUNT];
  logic [31:0]          user_int_enable;
  logic [31:0]          ctrl_wr_val;
  logic [31:0]          acc_next;
  logic [31:0]          cur;
  mdioc_pkg::rsp_t      rsp_next;

  mdioc_pkg::phy_req_t  phy_req;
  mdioc_pkg::phy_rsp_t  phy_rsp;

  // Handshake and pipeline flow
  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !rst && (!s1_valid || !rsp_valid || rsp_ready);
  assign req_xfer  = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_xfer) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      s1 <= req;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  // Offset decode
  always_comb begin
    hit = 1'b1;
    idx = mdioc_pkg::CTRL_REVISION;
    case (s1.offset)
      mdioc_pkg::OFS_REVISION:        idx = mdioc_pkg::CTRL_REVISION;
      mdioc_pkg::OFS_CONTROL:         idx = mdioc_pkg::CTRL_CONTROL;
      mdioc_pkg::OFS_ALIVE:           idx = mdioc_pkg::CTRL_ALIVE;
      mdioc_pkg::OFS_LINK:            idx = mdioc_pkg::CTRL_LINK;
      mdioc_pkg::OFS_LINK_INT_RAW:    idx = mdioc_pkg::CTRL_LINK_INT_RAW;
      mdioc_pkg::OFS_LINK_INT_MASKED: idx = mdioc_pkg::CTRL_LINK_INT_MASKED;
      mdioc_pkg::OFS_USER_INT_RAW:    idx = mdioc_pkg::CTRL_USER_INT_RAW;
      mdioc_pkg::OFS_USER_INT_MASKED: idx = mdioc_pkg::CTRL_USER_INT_MASKED;
      mdioc_pkg::OFS_USER_INT_SET:    idx = mdioc_pkg::CTRL_USER_INT_MASK_SET;
      mdioc_pkg::OFS_USER_INT_CLEAR:  idx = mdioc_pkg::CTRL_USER_INT_MASK_CLEAR;
      mdioc_pkg::OFS_USER_ACCESS0:    idx = mdioc_pkg::CTRL_USER_ACCESS0;
      mdioc_pkg::OFS_USER_PHYSEL0:    idx = mdioc_pkg::CTRL_USER_PHYSEL0;
      mdioc_pkg::OFS_USER_ACCESS1:    idx = mdioc_pkg::CTRL_USER_ACCESS1;
      mdioc_pkg::OFS_USER_PHYSEL1:    idx = mdioc_pkg::CTRL_USER_PHYSEL1;
      default:                        hit = 1'b0;
    endcase
  end

  assign cur       = ctrl_regs[idx];
  assign do_write  = advance && hit && (s1.op == mdioc_pkg::OP_WRITE);
  assign is_access = (idx == mdioc_pkg::CTRL_USER_ACCESS0) ||
                     (idx == mdioc_pkg::CTRL_USER_ACCESS1);

  // PHY transaction from a user access write with GO
  assign phy_req.wr     = do_write && is_access && s1.wdata[mdioc_pkg::ACC_GO_BIT] &&
                          s1.wdata[mdioc_pkg::ACC_WRITE_BIT];
  assign phy_req.regnum = s1.wdata[mdioc_pkg::ACC_REG_LSB +: 5];
  assign phy_req.data   = s1.wdata[15:0];

  mdioc_phy_regs u_phy (
    .clk (clk),
    .rst (rst),
    .req (phy_req),
    .rsp (phy_rsp)
  );

  // New user access value: read fills data and sets ack, GO clears
  always_comb begin
    acc_next = s1.wdata;
    if (s1.wdata[mdioc_pkg::ACC_GO_BIT]) begin
      if (!s1.wdata[mdioc_pkg::ACC_WRITE_BIT]) begin
        if (phy_rsp.hit) begin
          acc_next[15:0] = phy_rsp.rdata;
        end
        acc_next[mdioc_pkg::ACC_ACK_BIT] = 1'b1;
      end
      acc_next[mdioc_pkg::ACC_GO_BIT] = 1'b0;
    end
  end

  // Per-register write value
  always_comb begin
    ctrl_wr_val = s1.wdata;
    case (idx)
      mdioc_pkg::CTRL_CONTROL: begin
        // enable falling sets the idle bit, rising clears it
        if (cur[mdioc_pkg::CTRL_ENABLE_BIT] && !s1.wdata[mdioc_pkg::CTRL_ENABLE_BIT]) begin
          ctrl_wr_val[mdioc_pkg::CTRL_IDLE_BIT] = 1'b1;
        end
        if (!cur[mdioc_pkg::CTRL_ENABLE_BIT] && s1.wdata[mdioc_pkg::CTRL_ENABLE_BIT]) begin
          ctrl_wr_val[mdioc_pkg::CTRL_IDLE_BIT] = 1'b0;
        end
        ctrl_wr_val[mdioc_pkg::CTRL_SELFCLR_BIT] = 1'b0;
      end
      mdioc_pkg::CTRL_ALIVE,
      mdioc_pkg::CTRL_LINK_INT_RAW,
      mdioc_pkg::CTRL_LINK_INT_MASKED,
      mdioc_pkg::CTRL_USER_INT_RAW,
      mdioc_pkg::CTRL_USER_INT_MASKED: begin
        ctrl_wr_val = cur & ~s1.wdata;
      end
      mdioc_pkg::CTRL_USER_ACCESS0,
      mdioc_pkg::CTRL_USER_ACCESS1: begin
        ctrl_wr_val = acc_next;
      end
      default: begin
        ctrl_wr_val = s1.wdata;
      end
    endcase
  end

  // Controller register state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mdioc_pkg::CTRL_COUNT; i++) begin
        ctrl_regs[i] <= '0;
      end
      ctrl_regs[mdioc_pkg::CTRL_REVISION] <= mdioc_pkg::REVISION_RESET;
      ctrl_regs[mdioc_pkg::CTRL_CONTROL]  <= mdioc_pkg::CONTROL_RESET;
      ctrl_regs[mdioc_pkg::CTRL_ALIVE]    <= mdioc_pkg::PRESENCE_RESET;
      ctrl_regs[mdioc_pkg::CTRL_LINK]     <= mdioc_pkg::PRESENCE_RESET;
      user_int_enable <= '0;
    end else if (do_write) begin
      ctrl_regs[idx] <= ctrl_wr_val;
      if (idx == mdioc_pkg::CTRL_USER_INT_MASK_SET) begin
        user_int_enable <= user_int_enable | s1.wdata;
      end else if (idx == mdioc_pkg::CTRL_USER_INT_MASK_CLEAR) begin
        user_int_enable <= user_int_enable & ~s1.wdata;
      end
    end
  end

  // Response
  assign rsp_next.rdata      = (hit && (s1.op == mdioc_pkg::OP_READ)) ? cur : '0;
  assign rsp_next.bad_offset = !hit;

endmodule

`default_nettype wire

// ===== design/mdioc_checker.sv =====
`default_nettype none

`include "mdio_controller_with_phy_regs_core_defines.svh"

// Port-level checks of the MDIO controller.
module mdioc_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_valid,
  input wire logic            req_ready,
  input wire logic            rsp_valid,
  input wire logic            rsp_ready,
  input wire mdioc_pkg::rsp_t rsp
);

  // unknown offset never returns data
  `MDIOC_ASSERT_SAME(a_bad_offset_zero, clk, rst, rsp_valid && rsp.bad_offset, rsp.rdata == '0)

  // request side stalls only behind a blocked response
  `MDIOC_ASSERT_SAME(a_stall_cause, clk, rst, !req_ready, rsp_valid && !rsp_ready)

  // a fresh response traces back to an accepted request
  `MDIOC_ASSERT_SAME(a_rsp_origin, clk, rst, $rose(rsp_valid), $past(req_valid && req_ready, 2))

  // stalled response holds
  `MDIOC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind mdio_controller_with_phy_regs_core mdioc_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_mdio_controller_with_phy_regs_core.sv =====
`default_nettype none

module tb_mdio_controller_with_phy_regs_core;
  import mdioc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 900;

  // Known controller offsets and PHY register numbers, for picking legal targets
  localparam logic [7:0] KNOWN_OFS [CTRL_COUNT] = '{
    OFS_REVISION, OFS_CONTROL, OFS_ALIVE, OFS_LINK, OFS_LINK_INT_RAW,
    OFS_LINK_INT_MASKED, OFS_USER_INT_RAW, OFS_USER_INT_MASKED, OFS_USER_INT_SET,
    OFS_USER_INT_CLEAR, OFS_USER_ACCESS0, OFS_USER_PHYSEL0, OFS_USER_ACCESS1,
    OFS_USER_PHYSEL1
  };
  localparam logic [4:0] KNOWN_PHY [PHY_COUNT] = '{
    5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, PHY_REG_LAST_STD, PHY_REG_17, PHY_REG_18,
    PHY_REG_26, PHY_REG_27, PHY_REG_29, PHY_REG_30, PHY_REG_31
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Shadow of the controller and PHY register files
  logic [31:0] ctrl_shadow [CTRL_COUNT];
  logic [31:0] int_enable_shadow;
  logic [15:0] phy_shadow [PHY_COUNT];

  // Responses owed by the block, oldest first
  rsp_t access_results [$];

  int error_count = 0;
  int cycle_count = 0;
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;

  mdio_controller_with_phy_regs_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_mdio_controller_with_phy_regs_core: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register file shadow
  // ---------------------------------------------------------------------------

  function automatic void phy_soft_reset();
    for (int i = 0; i < PHY_COUNT; i++) phy_shadow[i] = PHY_RESET[i];
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < CTRL_COUNT; i++) ctrl_shadow[i] = '0;
    ctrl_shadow[CTRL_REVISION] = REVISION_RESET;
    ctrl_shadow[CTRL_CONTROL]  = CONTROL_RESET;
    ctrl_shadow[CTRL_ALIVE]    = PRESENCE_RESET;
    ctrl_shadow[CTRL_LINK]     = PRESENCE_RESET;
    int_enable_shadow = '0;
    phy_soft_reset();
  endfunction

  function automatic bit decode_offset(input logic [7:0] ofs, output ctrl_idx_t slot);
    slot = CTRL_REVISION;
    case (ofs)
      OFS_REVISION:        slot = CTRL_REVISION;
      OFS_CONTROL:         slot = CTRL_CONTROL;
      OFS_ALIVE:           slot = CTRL_ALIVE;
      OFS_LINK:            slot = CTRL_LINK;
      OFS_LINK_INT_RAW:    slot = CTRL_LINK_INT_RAW;
      OFS_LINK_INT_MASKED: slot = CTRL_LINK_INT_MASKED;
      OFS_USER_INT_RAW:    slot = CTRL_USER_INT_RAW;
      OFS_USER_INT_MASKED: slot = CTRL_USER_INT_MASKED;
      OFS_USER_INT_SET:    slot = CTRL_USER_INT_MASK_SET;
      OFS_USER_INT_CLEAR:  slot = CTRL_USER_INT_MASK_CLEAR;
      OFS_USER_ACCESS0:    slot = CTRL_USER_ACCESS0;
      OFS_USER_PHYSEL0:    slot = CTRL_USER_PHYSEL0;
      OFS_USER_ACCESS1:    slot = CTRL_USER_ACCESS1;
      OFS_USER_PHYSEL1:    slot = CTRL_USER_PHYSEL1;
      default:             return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit phy_slot(input logic [4:0] num, output int idx);
    idx = 0;
    if (num <= PHY_REG_LAST_STD) begin
      idx = int'(num);
      return 1'b1;
    end
    case (num)
      PHY_REG_17: idx = 7;
      PHY_REG_18: idx = 8;
      PHY_REG_26: idx = 9;
      PHY_REG_27: idx = 10;
      PHY_REG_29: idx = 11;
      PHY_REG_30: idx = 12;
      PHY_REG_31: idx = 13;
      default:    return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Runs the PHY transaction carried by a user access word, returns what is stored
  function automatic logic [31:0] phy_transaction(input logic [31:0] word);
    int  pi;
    bit  hit;
    hit = phy_slot(word[ACC_REG_LSB +: 5], pi);
    if (!word[ACC_GO_BIT]) return word;
    if (!word[ACC_WRITE_BIT]) begin
      if (hit) word[15:0] = phy_shadow[pi];
      word[ACC_ACK_BIT] = 1'b1;
    end else if (hit) begin
      if (pi == 0) begin
        if (word[PHY_SOFT_RESET_BIT]) begin
          phy_soft_reset();
        end else begin
          phy_shadow[0] = word[15:0];
          phy_shadow[0][PHY_SELFCLR_BIT] = 1'b0;
        end
      end else begin
        phy_shadow[pi] = word[15:0];
      end
    end
    word[ACC_GO_BIT] = 1'b0;
    return word;
  endfunction

  // One bus access against the shadow: updates it and returns the response
  function automatic rsp_t bus_access(input req_t a);
    rsp_t        r;
    ctrl_idx_t   slot;
    logic [31:0] nv;
    r = '0;
    if (!decode_offset(a.offset, slot)) begin
      r.bad_offset = 1'b1;
      return r;
    end
    if (a.op == OP_READ) begin
      r.rdata = ctrl_shadow[slot];
      return r;
    end
    case (slot)
      CTRL_CONTROL: begin
        nv = a.wdata;
        if (ctrl_shadow[CTRL_CONTROL][CTRL_ENABLE_BIT] && !a.wdata[CTRL_ENABLE_BIT])
          nv[CTRL_IDLE_BIT] = 1'b1;
        if (!ctrl_shadow[CTRL_CONTROL][CTRL_ENABLE_BIT] && a.wdata[CTRL_ENABLE_BIT])
          nv[CTRL_IDLE_BIT] = 1'b0;
        nv[CTRL_SELFCLR_BIT] = 1'b0;
        ctrl_shadow[CTRL_CONTROL] = nv;
      end
      CTRL_ALIVE, CTRL_LINK_INT_RAW, CTRL_LINK_INT_MASKED, CTRL_USER_INT_RAW,
      CTRL_USER_INT_MASKED: begin
        ctrl_shadow[slot] = ctrl_shadow[slot] & ~a.wdata;
      end
      CTRL_USER_INT_MASK_SET: begin
        ctrl_shadow[slot] = a.wdata;
        int_enable_shadow = int_enable_shadow | a.wdata;
      end
      CTRL_USER_INT_MASK_CLEAR: begin
        ctrl_shadow[slot] = a.wdata;
        int_enable_shadow = int_enable_shadow & ~a.wdata;
      end
      CTRL_USER_ACCESS0, CTRL_USER_ACCESS1: begin
        ctrl_shadow[slot] = phy_transaction(a.wdata);
      end
      default: begin
        ctrl_shadow[slot] = a.wdata;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus side
  // ---------------------------------------------------------------------------

  // User access word: go, direction, register number, PHY address, data
  function automatic logic [31:0] phy_cmd(input bit go, input bit wr, input logic [4:0] num,
                                          input logic [15:0] data);
    logic [31:0] w;
    w = '0;
    w[ACC_GO_BIT] = go;
    w[ACC_WRITE_BIT] = wr;
    w[ACC_REG_LSB +: 5] = num;
    w[20:16] = 5'(PHY_ADDRESS);
    w[15:0] = data;
    return w;
  endfunction

  task automatic issue_access(input logic op, input logic [7:0] ofs, input logic [31:0] data);
    req_t item;
    int   gap;
    item.op = op;
    item.offset = ofs;
    item.wdata = data;
    gap = src_idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_ready !== 1'b1);
    access_results.push_back(bus_access(item));
  endtask

  // Stop sending and wait for every owed response
  task automatic settle_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (access_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------

  task automatic log_error(input string what, input logic [31:0] want,
                           input logic [31:0] got);
    error_count++;
    if (error_count <= 10)
      $display("MISMATCH %s: expected %h, got %h", what, want, got);
  endtask

  initial begin : rsp_checker
    rsp_t got;
    rsp_t want;
    int   stall;
    forever begin
      stall = sink_idle_on ? $urandom_range(0, 4) : 0;
      @(negedge clk);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (rst || rsp_valid !== 1'b1);
      got = rsp;
      if (access_results.size() == 0) begin
        log_error("response with nothing pending", '0, got.rdata);
      end else begin
        want = access_results.pop_front();
        if (got.rdata !== want.rdata) log_error("rdata", want.rdata, got.rdata);
        if (got.bad_offset !== want.bad_offset)
          log_error("bad_offset", 32'(want.bad_offset), 32'(got.bad_offset));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_values();
    issue_access(OP_READ, OFS_REVISION, '0);
    issue_access(OP_READ, OFS_CONTROL, '1);
    issue_access(OP_READ, OFS_ALIVE, '0);
    issue_access(OP_READ, OFS_LINK, '0);
  endtask

  task automatic test_bad_offsets();
    issue_access(OP_READ, 8'hFF, '0);
    issue_access(OP_WRITE, 8'h01, 32'hFFFF_FFFF);
    issue_access(OP_READ, 8'h18, '0);
  endtask

  // Enable rising clears idle, falling sets it; bit 19 never reads back
  task automatic test_control_edges();
    issue_access(OP_WRITE, OFS_CONTROL, 32'hFFFF_FFFF);
    issue_access(OP_READ, OFS_CONTROL, '0);
    issue_access(OP_WRITE, OFS_CONTROL, 32'h0008_0000);
    issue_access(OP_READ, OFS_CONTROL, '0);
  endtask

  task automatic test_clear_on_one();
    issue_access(OP_WRITE, OFS_ALIVE, 32'h0000_0001);
    issue_access(OP_READ, OFS_ALIVE, '0);
  endtask

  task automatic test_phy_access();
    // plain PHY read
    issue_access(OP_WRITE, OFS_USER_ACCESS0, phy_cmd(1'b1, 1'b0, 5'd1, '0));
    issue_access(OP_READ, OFS_USER_ACCESS0, '0);
    // PHY control write with the self-clearing bit set
    issue_access(OP_WRITE, OFS_USER_ACCESS1, phy_cmd(1'b1, 1'b1, 5'd0, 16'h3300));
    issue_access(OP_WRITE, OFS_USER_ACCESS1, phy_cmd(1'b1, 1'b0, 5'd0, '0));
    issue_access(OP_READ, OFS_USER_ACCESS1, '0);
    // top register overwritten, then restored by soft reset
    issue_access(OP_WRITE, OFS_USER_ACCESS0, phy_cmd(1'b1, 1'b1, PHY_REG_31, 16'hFFFF));
    issue_access(OP_WRITE, OFS_USER_ACCESS0, phy_cmd(1'b1, 1'b1, 5'd0, 16'h8000));
    issue_access(OP_WRITE, OFS_USER_ACCESS0, phy_cmd(1'b1, 1'b0, PHY_REG_31, '0));
    issue_access(OP_READ, OFS_USER_ACCESS0, '0);
    // unknown PHY register: read keeps data and acks, write is dropped
    issue_access(OP_WRITE, OFS_USER_ACCESS1, phy_cmd(1'b1, 1'b0, 5'd7, 16'hABCD));
    issue_access(OP_READ, OFS_USER_ACCESS1, '0);
    issue_access(OP_WRITE, OFS_USER_ACCESS0, phy_cmd(1'b1, 1'b1, 5'd8, 16'h1234));
    // no GO: stored as written
    issue_access(OP_WRITE, OFS_USER_ACCESS0, phy_cmd(1'b0, 1'b1, 5'd2, 16'h5555));
    issue_access(OP_READ, OFS_USER_ACCESS0, '0);
  endtask

  task automatic test_random_traffic(input int count);
    int          sent;
    int          burst_left;
    int          pick;
    bit          drained;
    logic [7:0]  ofs;
    logic [31:0] word;
    sent = 0;
    burst_left = 0;
    drained = 1'b0;
    while (sent < count) begin
      // switch between idling and full-rate stretches
      if (burst_left <= 0) begin
        burst_left = $urandom_range(20, 80);
        src_idle_on = $urandom_range(0, 3) != 0;
        sink_idle_on = $urandom_range(0, 3) != 0;
      end
      if (!drained && sent >= count / 2) begin
        settle_results();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      word = $urandom;
      if (pick < 10) begin
        // noise: any offset, any op
        issue_access(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), word);
        sent += 1;
      end else if (pick < 45) begin
        // PHY transaction followed by a read of the access register
        ofs = $urandom_range(0, 1) ? OFS_USER_ACCESS1 : OFS_USER_ACCESS0;
        word[ACC_GO_BIT] = $urandom_range(0, 7) != 0;
        if ($urandom_range(0, 4) != 0)
          word[ACC_REG_LSB +: 5] = KNOWN_PHY[$urandom_range(0, PHY_COUNT - 1)];
        issue_access(OP_WRITE, ofs, word);
        issue_access(OP_READ, ofs, $urandom);
        sent += 2;
      end else if (pick < 58) begin
        issue_access(OP_WRITE, OFS_CONTROL, word);
        issue_access(OP_READ, OFS_CONTROL, $urandom);
        sent += 2;
      end else begin
        issue_access(1'($urandom_range(0, 1)), KNOWN_OFS[$urandom_range(0, CTRL_COUNT - 1)],
                     word);
        sent += 1;
      end
      burst_left -= 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    shadow_reset();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_bad_offsets();
    test_control_edges();
    settle_results();
    test_clear_on_one();
    test_phy_access();
    test_random_traffic(RANDOM_ITEMS);
    settle_results();
    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_mdio_controller_with_phy_regs_core: clean");
    end else begin
      $display("tb_mdio_controller_with_phy_regs_core: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
